>>> rtl/gdau_pkg.sv
// Shared types, constants and calendar helper functions for the date arithmetic unit.
package gdau_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned QUOT_W  = 8;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd16383;

    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int unsigned DIV100_SHIFT = 19;

    typedef enum logic [OP_W-1:0] {
        OP_WEEKDAY     = 3'd0,
        OP_NEXT_DAY    = 3'd1,
        OP_NEXT_MONTH  = 3'd2,
        OP_NEXT_YEAR   = 3'd3,
        OP_NEXT_MONDAY = 3'd4
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [2:0] MONTH_SHIFT [12] = '{
        3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4,
        3'd6, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5
    };

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               leap_y;
        logic               leap_n;
        logic [DAY_W-1:0]   mlen;
        logic               valid;
        logic [WDAY_W-1:0]  wday;
    } date_info_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [WDAY_W-1:0]  wday;
        logic [STAT_W-1:0]  status;
    } date_result_t;

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (m == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m >= 4'd1 && m <= 4'd12) begin
            len = MONTH_LEN[m - 4'd1];
        end
        return len;
    endfunction

    function automatic logic [2:0] month_shift(input logic [MONTH_W-1:0] m);
        logic [2:0] s;
        s = 3'd0;
        if (m >= 4'd1 && m <= 4'd12) begin
            s = MONTH_SHIFT[m - 4'd1];
        end
        return s;
    endfunction

    // fold octal digits, since 8 is 1 modulo 7
    function automatic logic [2:0] mod7(input logic [15:0] x);
        logic [5:0] f1;
        logic [3:0] f2;
        logic [3:0] r;
        f1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
             + 6'(x[15]);
        f2 = 4'(f1[2:0]) + 4'(f1[5:3]);
        r  = (f2 >= 4'd7) ? (f2 - 4'd7) : f2;
        return r[2:0];
    endfunction

    function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W:0] x);
        logic [27:0] prod;
        prod = 28'(x) * 28'(DIV100_MUL);
        return prod[DIV100_SHIFT +: QUOT_W];
    endfunction

endpackage

>>> rtl/gdau_next_date.sv
// Result date selection: next day, next month, next year, next Monday, with status.
module gdau_next_date (
    input  gdau_pkg::date_info_t   info,
    output gdau_pkg::date_result_t res
);

    logic [3:0]                      add;
    logic [5:0]                      sum;
    logic [gdau_pkg::MONTH_W-1:0]    nm;
    logic                            wrap;
    logic [gdau_pkg::DAY_W-1:0]      lim;
    logic                            inc;
    logic [gdau_pkg::DAY_W-1:0]      rd;
    logic [gdau_pkg::MONTH_W-1:0]    rm;

    assign add  = (info.op == gdau_pkg::OP_NEXT_DAY || info.wday == 3'd0) ?
                  4'd1 : (4'd8 - 4'(info.wday));
    assign sum  = 6'(info.day) + 6'(add);
    assign wrap = (info.month == 4'd12);
    assign nm   = wrap ? 4'd1 : (info.month + 4'd1);
    assign lim  = gdau_pkg::days_in(nm, info.leap_y);

    always_comb begin
        rd  = info.day;
        rm  = info.month;
        inc = 1'b0;
        case (info.op)
            gdau_pkg::OP_NEXT_DAY, gdau_pkg::OP_NEXT_MONDAY: begin
                if (sum > 6'(info.mlen)) begin
                    rd  = 5'(sum - 6'(info.mlen));
                    rm  = nm;
                    inc = wrap;
                end else begin
                    rd = sum[4:0];
                end
            end
            gdau_pkg::OP_NEXT_MONTH: begin
                rm  = nm;
                inc = wrap;
                if (info.day > lim) begin
                    rd = lim;
                end
            end
            gdau_pkg::OP_NEXT_YEAR: begin
                inc = 1'b1;
                if (info.month == 4'd2 && info.day == 5'd29 && !info.leap_n) begin
                    rd = 5'd1;
                    rm = 4'd3;
                end
            end
            default: begin
            end
        endcase

        res.day    = rd;
        res.month  = rm;
        res.year   = info.year + 14'(inc);
        res.wday   = info.wday;
        res.status = gdau_pkg::ST_OK;
        if (!info.valid) begin
            res.day    = info.day;
            res.month  = info.month;
            res.year   = info.year;
            res.wday   = 3'd0;
            res.status = gdau_pkg::ST_INVALID;
        end else if (inc && info.year == gdau_pkg::YEAR_MAX) begin
            res.day    = info.day;
            res.month  = info.month;
            res.year   = info.year;
            res.status = gdau_pkg::ST_OVERFLOW;
        end
    end

endmodule

>>> rtl/gregorian_date_arithmetic_unit_core.sv
// Top level of the Gregorian date arithmetic unit: four-stage date pipeline.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_opcode, s_in_day, s_in_month, s_in_year
//  m_      | out       | m_valid / m_ready  | m_out_day, m_out_month, m_out_year,
//          |           |                    | m_weekday, m_status
//
// One transaction per cycle while m_ready is high; m_valid follows stages a, b and c.
// Stages: year divides by 100 (multiply by reciprocal), leap and January 1st weekday,
// weekday of the date, result date into the output register.
// Each stage takes a new transaction when it is empty or its successor moves, so
// bubbles collapse and a stalled output still lets earlier stages fill.
// Synchronous active-low reset clears the valid bits only.
module gregorian_date_arithmetic_unit_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gdau_pkg::OP_W-1:0]    s_opcode,
    input  logic [gdau_pkg::DAY_W-1:0]   s_in_day,
    input  logic [gdau_pkg::MONTH_W-1:0] s_in_month,
    input  logic [gdau_pkg::YEAR_W-1:0]  s_in_year,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gdau_pkg::DAY_W-1:0]   m_out_day,
    output logic [gdau_pkg::MONTH_W-1:0] m_out_month,
    output logic [gdau_pkg::YEAR_W-1:0]  m_out_year,
    output logic [gdau_pkg::WDAY_W-1:0]  m_weekday,
    output logic [gdau_pkg::STAT_W-1:0]  m_status
);

    localparam int unsigned YW = gdau_pkg::YEAR_W;

    // stage a
    logic                          a_valid_reg;
    logic [gdau_pkg::OP_W-1:0]     a_op_reg;
    logic [gdau_pkg::DAY_W-1:0]    a_day_reg;
    logic [gdau_pkg::MONTH_W-1:0]  a_month_reg;
    logic [YW-1:0]                 a_year_reg;
    logic [gdau_pkg::QUOT_W-1:0]   a_qp_reg;
    logic [gdau_pkg::QUOT_W-1:0]   a_qy_reg;
    logic [gdau_pkg::QUOT_W-1:0]   a_qn_reg;

    // stage b
    logic                          b_valid_reg;
    gdau_pkg::date_info_t          b_info_reg;
    logic [2:0]                    b_jan1_reg;

    // stage c
    logic                          c_valid_reg;
    gdau_pkg::date_info_t          c_info_reg;

    // output stage
    logic                          m_valid_reg;
    gdau_pkg::date_result_t        m_res_reg;

    logic a_ready, b_ready, c_ready, d_ready;

    logic [YW-1:0]                 s_prev_year;
    logic [YW:0]                   s_next_year;

    logic [YW-1:0]                 a_prev;
    logic [YW:0]                   a_next;
    logic                          a_leap_y;
    logic                          a_leap_n;
    logic [gdau_pkg::DAY_W-1:0]    a_mlen;
    logic                          a_date_ok;
    logic [15:0]                   a_jan1_sum;
    gdau_pkg::date_info_t          b_info_next;

    logic [15:0]                   b_wsum;
    gdau_pkg::date_info_t          c_info_next;

    gdau_pkg::date_result_t        d_res_next;

    assign d_ready = !m_valid_reg || m_ready;
    assign c_ready = !c_valid_reg || d_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;

    // stage a: quotients by 100 of year - 1, year, year + 1
    assign s_prev_year = s_in_year - 14'd1;
    assign s_next_year = (YW+1)'(s_in_year) + 15'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid;
        end
        if (a_ready) begin
            a_op_reg    <= s_opcode;
            a_day_reg   <= s_in_day;
            a_month_reg <= s_in_month;
            a_year_reg  <= s_in_year;
            a_qp_reg    <= gdau_pkg::div100({1'b0, s_prev_year});
            a_qy_reg    <= gdau_pkg::div100({1'b0, s_in_year});
            a_qn_reg    <= gdau_pkg::div100(s_next_year);
        end
    end

    // stage b: leap years, validity, January 1st weekday
    assign a_prev   = a_year_reg - 14'd1;
    assign a_next   = (YW+1)'(a_year_reg) + 15'd1;
    assign a_leap_y = (a_year_reg[1:0] == 2'd0) &&
                      ((a_qy_reg == a_qp_reg) || (a_qy_reg[1:0] == 2'd0));
    assign a_leap_n = (a_next[1:0] == 2'd0) &&
                      ((a_qn_reg == a_qy_reg) || (a_qn_reg[1:0] == 2'd0));
    assign a_mlen   = gdau_pkg::days_in(a_month_reg, a_leap_y);
    assign a_date_ok = (a_month_reg >= 4'd1) && (a_month_reg <= 4'd12) &&
                       (a_year_reg != 14'd0) && (a_day_reg != 5'd0) &&
                       (a_day_reg <= a_mlen);
    assign a_jan1_sum = 16'(a_year_reg) + 16'(a_prev[YW-1:2]) - 16'(a_qp_reg)
                        + 16'(a_qp_reg[gdau_pkg::QUOT_W-1:2]);

    always_comb begin
        b_info_next.op     = a_op_reg;
        b_info_next.day    = a_day_reg;
        b_info_next.month  = a_month_reg;
        b_info_next.year   = a_year_reg;
        b_info_next.leap_y = a_leap_y;
        b_info_next.leap_n = a_leap_n;
        b_info_next.mlen   = a_mlen;
        b_info_next.valid  = a_date_ok;
        b_info_next.wday   = 3'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
        if (b_ready) begin
            b_info_reg <= b_info_next;
            b_jan1_reg <= gdau_pkg::mod7(a_jan1_sum);
        end
    end

    // stage c: weekday of the input date
    assign b_wsum = 16'(b_jan1_reg) + 16'(gdau_pkg::month_shift(b_info_reg.month))
                    + 16'(b_info_reg.day) - 16'd1
                    + 16'((b_info_reg.month > 4'd2) && b_info_reg.leap_y);

    always_comb begin
        c_info_next      = b_info_reg;
        c_info_next.wday = b_info_reg.valid ? gdau_pkg::mod7(b_wsum) : 3'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (c_ready) begin
            c_valid_reg <= b_valid_reg;
        end
        if (c_ready) begin
            c_info_reg <= c_info_next;
        end
    end

    // output stage: result date
    gdau_next_date u_next_date (
        .info (c_info_reg),
        .res  (d_res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (d_ready) begin
            m_valid_reg <= c_valid_reg;
        end
        if (d_ready) begin
            m_res_reg <= d_res_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_day   = m_res_reg.day;
    assign m_out_month = m_res_reg.month;
    assign m_out_year  = m_res_reg.year;
    assign m_weekday   = m_res_reg.wday;
    assign m_status    = m_res_reg.status;

`ifndef NO_ASSERTIONS
    a_invalid_weekday: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == gdau_pkg::ST_INVALID |-> m_weekday == 3'd0)
        else $error("invalid transaction carries a weekday");

    a_overflow_year: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == gdau_pkg::ST_OVERFLOW |-> m_out_year == gdau_pkg::YEAR_MAX)
        else $error("overflow flagged below the last year");

    a_ok_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == gdau_pkg::ST_OK |->
        m_out_month >= 4'd1 && m_out_month <= 4'd12 && m_out_day != 5'd0 &&
        m_out_year != 14'd0 && m_weekday <= 3'd6)
        else $error("result date out of range");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && a_valid_reg && b_valid_reg && c_valid_reg |-> !s_ready)
        else $error("input taken while the pipeline is full and stalled");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && !c_ready |=> c_valid_reg && $stable(c_info_reg))
        else $error("stalled stage lost its transaction");
`endif

endmodule
